>>> hw/rtl/rar_pkg.sv
// Shared types and constants for the rational arithmetic reducer.
package rar_pkg;

  localparam int unsigned OperandBitsDef = 16;
  localparam int unsigned NumOutBits     = 33;
  localparam int unsigned DenOutBits     = 32;
  localparam int unsigned QueueDepth     = 2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_GCD,
    BK_DIVN,
    BK_DIVD,
    BK_OUT
  } bk_state_t;

endpackage

>>> hw/rtl/rar_front.sv
// Front part: take operands, form the raw numerator and denominator, classify.
module rar_front #(
  parameter int unsigned OPERAND_BITS = rar_pkg::OperandBitsDef,
  parameter int unsigned RAW_BITS     = 2 * OPERAND_BITS + 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_op,
  input  logic [OPERAND_BITS-1:0] in_a_num,
  input  logic [OPERAND_BITS-1:0] in_a_den,
  input  logic [OPERAND_BITS-1:0] in_b_num,
  input  logic [OPERAND_BITS-1:0] in_b_den,
  output logic                    q_valid,
  input  logic                    q_ready,
  output logic                    q_num_neg,
  output logic [RAW_BITS-1:0]     q_num_mag,
  output logic                    q_den_neg,
  output logic [RAW_BITS-1:0]     q_den_mag,
  output logic                    q_err
);

  localparam int unsigned MB = 2 * OPERAND_BITS;

  // stage 1: magnitudes and products
  logic          s1_v_r;
  logic          s1_err_r;
  logic          s1_twoterm_r;
  logic          s1_p0neg_r, s1_p1neg_r, s1_dneg_r;
  logic [MB-1:0] s1_p0_r, s1_p1_r, s1_d_r;

  logic [OPERAND_BITS-1:0] an_m, ad_m, bn_m, bd_m;
  logic                    an_s, ad_s, bn_s, bd_s;
  logic [OPERAND_BITS-1:0] x0, y0, x1, y1, x2, y2;
  logic                    x0s, y0s, x1s, y1s, x2s, y2s;
  logic                    t_neg;
  rar_pkg::op_t            op;
  logic                    s1_adv;

  always_comb begin
    op   = rar_pkg::op_t'(in_op);
    an_s = in_a_num[OPERAND_BITS-1];
    ad_s = in_a_den[OPERAND_BITS-1];
    bn_s = in_b_num[OPERAND_BITS-1];
    bd_s = in_b_den[OPERAND_BITS-1];
    an_m = an_s ? (~in_a_num + 1'b1) : in_a_num;
    ad_m = ad_s ? (~in_a_den + 1'b1) : in_a_den;
    bn_m = bn_s ? (~in_b_num + 1'b1) : in_b_num;
    bd_m = bd_s ? (~in_b_den + 1'b1) : in_b_den;
    x0 = an_m; x0s = an_s; y0 = bd_m; y0s = bd_s;
    x1 = ad_m; x1s = ad_s; y1 = bn_m; y1s = bn_s;
    x2 = ad_m; x2s = ad_s; y2 = bd_m; y2s = bd_s;
    t_neg = 1'b0;
    case (op)
      rar_pkg::OP_SUB: t_neg = 1'b1;
      rar_pkg::OP_MUL: begin
        y0 = bn_m; y0s = bn_s;
      end
      rar_pkg::OP_DIV: begin
        x2 = bn_m; x2s = bn_s; y2 = ad_m; y2s = ad_s;
      end
      default: ;
    endcase
  end

  // stage 2: signed-magnitude sum
  logic              s2_v_r;
  logic              s2_err_r;
  logic              s2_nneg_r, s2_dneg_r;
  logic [RAW_BITS-1:0] s2_n_r, s2_d_r;

  assign s1_adv = s1_v_r && (!s2_v_r || q_ready);
  assign in_ready = !s1_v_r || (!s2_v_r || q_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_err_r     <= (op == rar_pkg::OP_DIV) && (bn_m == '0);
      s1_twoterm_r <= (op == rar_pkg::OP_ADD) || (op == rar_pkg::OP_SUB);
      s1_p0_r      <= MB'(x0) * MB'(y0);
      s1_p0neg_r   <= x0s ^ y0s;
      s1_p1_r      <= MB'(x1) * MB'(y1);
      s1_p1neg_r   <= x1s ^ y1s ^ t_neg;
      s1_d_r       <= MB'(x2) * MB'(y2);
      s1_dneg_r    <= x2s ^ y2s;
    end
  end

  logic [RAW_BITS-1:0] a0, a1, sum;
  logic                sneg;
  always_comb begin
    a0 = RAW_BITS'(s1_p0_r);
    a1 = s1_twoterm_r ? RAW_BITS'(s1_p1_r) : '0;
    sneg = s1_p0neg_r;
    if (!s1_twoterm_r || (s1_p0neg_r == s1_p1neg_r)) begin
      sum = a0 + a1;
    end else if (a0 >= a1) begin
      sum = a0 - a1;
    end else begin
      sum  = a1 - a0;
      sneg = s1_p1neg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (!s2_v_r || q_ready) begin
      s2_v_r <= s1_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_err_r  <= s1_err_r || (s1_d_r == '0);
      s2_n_r    <= sum;
      s2_nneg_r <= sneg;
      s2_d_r    <= RAW_BITS'(s1_d_r);
      s2_dneg_r <= s1_dneg_r;
    end
  end

  assign q_valid   = s2_v_r;
  assign q_num_neg = s2_nneg_r;
  assign q_num_mag = s2_n_r;
  assign q_den_neg = s2_dneg_r;
  assign q_den_mag = s2_d_r;
  assign q_err     = s2_err_r;

endmodule

>>> hw/rtl/rar_queue.sv
// Short queue between the front and back parts.
module rar_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = rar_pkg::QueueDepth
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          wr, rd;

  assign wr_ready = cnt_r != (AW+1)'(DEPTH);
  assign rd_valid = cnt_r != '0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (rd) begin
        rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

>>> hw/rtl/rar_back.sv
// Back part: binary GCD, two restoring divisions, output register.
module rar_back #(
  parameter int unsigned RAW_BITS = 33
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  logic                 q_num_neg,
  input  logic [RAW_BITS-1:0]  q_num_mag,
  input  logic                 q_den_neg,
  input  logic [RAW_BITS-1:0]  q_den_mag,
  input  logic                 q_err,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [rar_pkg::NumOutBits-1:0] res_num,
  output logic [rar_pkg::DenOutBits-1:0] res_den,
  output logic                 status
);

  localparam int unsigned CW = $clog2(RAW_BITS + 1);
  localparam int unsigned NO = rar_pkg::NumOutBits;
  localparam int unsigned DO = rar_pkg::DenOutBits;

  rar_pkg::bk_state_t st_r, st_nxt;

  logic [RAW_BITS-1:0] n_r, d_r, u_r, v_r, quo_r, rem_r, g_r, qn_r;
  logic [CW-1:0]       sh_r, cnt_r;
  logic                nneg_r, dneg_r;
  logic [NO-1:0]       onum_r;
  logic [DO-1:0]       oden_r;
  logic                ost_r;

  logic [RAW_BITS:0]   trial;
  assign trial = {rem_r, quo_r[RAW_BITS-1]} - {1'b0, g_r};

  always_comb begin
    st_nxt  = st_r;
    q_ready = 1'b0;
    case (st_r)
      rar_pkg::BK_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          st_nxt = (q_err || q_num_mag == '0) ? rar_pkg::BK_OUT : rar_pkg::BK_GCD;
        end
      end
      rar_pkg::BK_GCD: begin
        if (u_r != '0 && v_r != '0 && (u_r == v_r)) st_nxt = rar_pkg::BK_DIVN;
      end
      rar_pkg::BK_DIVN: begin
        if (cnt_r == CW'(RAW_BITS - 1)) st_nxt = rar_pkg::BK_DIVD;
      end
      rar_pkg::BK_DIVD: begin
        if (cnt_r == CW'(RAW_BITS - 1)) st_nxt = rar_pkg::BK_OUT;
      end
      rar_pkg::BK_OUT: begin
        if (!out_valid || out_ready) st_nxt = rar_pkg::BK_IDLE;
      end
      default: st_nxt = rar_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rar_pkg::BK_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      rar_pkg::BK_IDLE: begin
        if (q_valid) begin
          n_r    <= q_num_mag;
          d_r    <= q_den_mag;
          u_r    <= q_num_mag;
          v_r    <= q_den_mag;
          nneg_r <= q_num_neg;
          dneg_r <= q_den_neg;
          sh_r   <= '0;
          ost_r  <= q_err;
          onum_r <= '0;
          oden_r <= q_err ? '0 : DO'(1);
        end
      end
      rar_pkg::BK_GCD: begin
        // binary GCD: strip common twos, then subtract odd from odd
        if (u_r == v_r) begin
          g_r   <= u_r << sh_r;
          quo_r <= n_r;
          rem_r <= '0;
          cnt_r <= '0;
        end else if (!u_r[0] && !v_r[0]) begin
          u_r  <= u_r >> 1;
          v_r  <= v_r >> 1;
          sh_r <= sh_r + 1'b1;
        end else if (!u_r[0]) begin
          u_r <= u_r >> 1;
        end else if (!v_r[0]) begin
          v_r <= v_r >> 1;
        end else if (u_r > v_r) begin
          u_r <= (u_r - v_r) >> 1;
        end else begin
          v_r <= (v_r - u_r) >> 1;
        end
      end
      rar_pkg::BK_DIVN, rar_pkg::BK_DIVD: begin
        if (!trial[RAW_BITS]) begin
          rem_r <= trial[RAW_BITS-1:0];
          quo_r <= {quo_r[RAW_BITS-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[RAW_BITS-2:0], quo_r[RAW_BITS-1]};
          quo_r <= {quo_r[RAW_BITS-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(RAW_BITS - 1)) begin
          if (st_r == rar_pkg::BK_DIVN) begin
            qn_r  <= {quo_r[RAW_BITS-2:0], !trial[RAW_BITS]};
            quo_r <= d_r;
            rem_r <= '0;
            cnt_r <= '0;
          end else begin
            // negate at the output width so the sign wraps there
            onum_r <= nneg_r ? (~NO'(qn_r) + NO'(1)) : NO'(qn_r);
            oden_r <= dneg_r ? (~DO'({quo_r[RAW_BITS-2:0], !trial[RAW_BITS]}) + DO'(1))
                             : DO'({quo_r[RAW_BITS-2:0], !trial[RAW_BITS]});
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (st_r == rar_pkg::BK_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == rar_pkg::BK_OUT && (!out_valid || out_ready)) begin
      res_num <= onum_r;
      res_den <= oden_r;
      status  <= ost_r;
    end
  end

endmodule

>>> hw/rtl/rational_arith_reduce.sv
// Top level of the rational arithmetic reducer with GCD reduction.
// Combines two signed fractions with add, subtract, multiply or divide and
// reduces the raw result by the GCD of numerator and denominator magnitudes.
// Input channel in_*: in_tdata carries op and four operands; one result item
// leaves on out_* per input item, in order.
// The front part (two stages) forms the raw pair with one multiplier stage and
// one add stage, then hands it through a two-entry queue to the back part.
// The back part runs a binary GCD, then two restoring divisions, one bit a
// cycle, and registers the result. Errors and zero numerators skip the GCD
// and the divisions. The back part takes a new item only while idle, so
// its GCD loop and divider set the throughput.
// Synchronous active-low reset empties all stages and the queue.
// When the receiver stalls, the result holds in the output register, the back
// part waits, and the queue and front part fill before in_tready drops.
module rational_arith_reduce #(
  parameter int unsigned OPERAND_BITS = rar_pkg::OperandBitsDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // op[1:0], a_num, a_den, b_num, b_den (from bit 0 up), zero padded
  input  logic [((2 + 4*OPERAND_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // res_num[32:0], res_den[64:33], status[65], zero padded
  output logic [71:0] out_tdata
);

  localparam int unsigned RB = 2 * OPERAND_BITS + 1;
  localparam int unsigned QW = 2 * RB + 3;

  logic                    fq_valid, fq_ready, bq_valid, bq_ready;
  logic                    f_nneg, f_dneg, f_err;
  logic [RB-1:0]           f_n, f_d;
  logic [QW-1:0]           fq_data, bq_data;
  logic [rar_pkg::NumOutBits-1:0] res_num;
  logic [rar_pkg::DenOutBits-1:0] res_den;
  logic                    status;

  rar_front #(.OPERAND_BITS(OPERAND_BITS), .RAW_BITS(RB)) u_front (
    .clk, .rst_n,
    .in_valid (in_tvalid), .in_ready(in_tready),
    .in_op    (in_tdata[1:0]),
    .in_a_num (in_tdata[2 +: OPERAND_BITS]),
    .in_a_den (in_tdata[2 + OPERAND_BITS +: OPERAND_BITS]),
    .in_b_num (in_tdata[2 + 2*OPERAND_BITS +: OPERAND_BITS]),
    .in_b_den (in_tdata[2 + 3*OPERAND_BITS +: OPERAND_BITS]),
    .q_valid  (fq_valid), .q_ready(fq_ready),
    .q_num_neg(f_nneg), .q_num_mag(f_n),
    .q_den_neg(f_dneg), .q_den_mag(f_d), .q_err(f_err)
  );

  assign fq_data = {f_err, f_dneg, f_d, f_nneg, f_n};

  rar_queue #(.W(QW), .DEPTH(rar_pkg::QueueDepth)) u_queue (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
    .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_data)
  );

  rar_back #(.RAW_BITS(RB)) u_back (
    .clk, .rst_n,
    .q_valid  (bq_valid), .q_ready(bq_ready),
    .q_num_mag(bq_data[RB-1:0]),
    .q_num_neg(bq_data[RB]),
    .q_den_mag(bq_data[RB+1 +: RB]),
    .q_den_neg(bq_data[2*RB+1]),
    .q_err    (bq_data[2*RB+2]),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .res_num, .res_den, .status
  );

  assign out_tdata = {6'd0, status, res_den, res_num};

  // result holds while the receiver stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");
  // an error result carries zero fields
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status |-> res_num == '0 && res_den == '0)
    else $error("error result not zero");
  // a good result never has a zero denominator (checked for OPERAND_BITS up to 16)
  a_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !status && OPERAND_BITS <= 16 |-> res_den != '0)
    else $error("zero denominator on good result");

endmodule
